// File: hw/rtl/ultrasonic_range_kalman_defines.svh
// Assertion macros shared by the ultrasonic ranging RTL.
// Needs a clock i_clk and an active-low reset i_rst_n in the including module.
`ifndef ULTRASONIC_RANGE_KALMAN_DEFINES_SVH
`define ULTRASONIC_RANGE_KALMAN_DEFINES_SVH

// same-cycle implication
`define URK_ASSERT_IMM(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define URK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/urk_pkg.sv
// Package for the ultrasonic ranging block: widths, constants and shared types.
// No dependencies.
`default_nettype none

package urk_pkg;

    localparam int TRIGGER_TICKS = 10;
    localparam int SENSOR_COUNT  = 3;
    localparam int FRAC_BITS     = 16;

    localparam int SENSOR_W = 2;
    localparam int LEVEL_W  = 3;
    localparam int TICK_W   = 20;
    localparam int NOISE_W  = 16;
    localparam int RAW_W    = 18;
    localparam int EST_W    = RAW_W + FRAC_BITS;
    localparam int COV_W    = 40;
    localparam int DEN_W    = COV_W + 1;
    localparam int REM_W    = COV_W + 2;
    localparam int ALU_W    = COV_W + FRAC_BITS + 2;
    localparam int CNT_W    = $clog2(FRAC_BITS + 2);

    // raw = floor(width * 17 / 100) = (width * ceil(17 * 2^32 / 100)) >> 32 for 20-bit widths
    localparam int RAW_MUL_W   = 30;
    localparam int RAW_SHIFT   = 32;
    localparam logic [RAW_MUL_W-1:0] RAW_MUL = 30'd730144441;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [TICK_W-1:0]  TIMEOUT_RST = 20'd50000;
    localparam logic [NOISE_W-1:0] MNOISE_RST  = 16'd40;
    localparam logic [NOISE_W-1:0] PNOISE_RST  = 16'd10;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [1:0] {
        REG_TIMEOUT = 2'd0,
        REG_MNOISE  = 2'd1,
        REG_PNOISE  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [TICK_W-1:0]  timeout;
        logic [NOISE_W-1:0] mnoise;
        logic [NOISE_W-1:0] pnoise;
    } t_cfg;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        t_alu_op          op;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             carry;   // on subtract: a >= b
    } t_alu_rsp;

endpackage

`default_nettype wire

// File: hw/rtl/urk_in_if.sv
// Input channel: one command or tick word with valid/ready.
// Depends on urk_pkg.
`default_nettype none

interface urk_in_if import urk_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                command;
    logic [SENSOR_W-1:0] sensor;
    logic [LEVEL_W-1:0]  echo_levels;

    modport source (output valid, output command, output sensor, output echo_levels,
                    input ready);
    modport sink   (input valid, input command, input sensor, input echo_levels,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/urk_out_if.sv
// Output channel: one status/result word with valid/ready.
// Depends on urk_pkg.
`default_nettype none

interface urk_out_if import urk_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             trigger;
    logic             busy_res;
    logic             done_res;
    logic [RAW_W-1:0] raw_distance;
    logic [RAW_W-1:0] kalman_distance;

    modport source (output valid, output trigger, output busy_res, output done_res,
                    output raw_distance, output kalman_distance, input ready);
    modport sink   (input valid, input trigger, input busy_res, input done_res,
                    input raw_distance, input kalman_distance, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/urk_regs.sv
// APB configuration registers: echo timeout, measurement and process noise.
// Depends on urk_pkg.
`default_nettype none

module urk_regs import urk_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [TICK_W-1:0]  r_timeout;
    logic [NOISE_W-1:0] r_mnoise;
    logic [NOISE_W-1:0] r_pnoise;
    logic [1:0]         w_idx;
    logic               w_wr;

    assign w_idx  = paddr[PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_mnoise  <= MNOISE_RST;
            r_pnoise  <= PNOISE_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_TIMEOUT: r_timeout <= pwdata[TICK_W-1:0];
                REG_MNOISE:  r_mnoise  <= pwdata[NOISE_W-1:0];
                REG_PNOISE:  r_pnoise  <= pwdata[NOISE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TIMEOUT: prdata = PDATA_W'(r_timeout);
            REG_MNOISE:  prdata = PDATA_W'(r_mnoise);
            REG_PNOISE:  prdata = PDATA_W'(r_pnoise);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.timeout = r_timeout;
    assign o_cfg.mnoise  = r_mnoise;
    assign o_cfg.pnoise  = r_pnoise;

endmodule

`default_nettype wire

// File: hw/rtl/urk_alu.sv
// Shared add/subtract unit of the filter datapath; carry out doubles as a >= b.
// Depends on urk_pkg.
`default_nettype none

module urk_alu import urk_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic             w_sub;
    logic [ALU_W-1:0] w_b;
    logic [ALU_W:0]   w_full;

    assign w_sub  = (i_req.op == ALU_SUB);
    assign w_b    = w_sub ? ~i_req.b : i_req.b;
    assign w_full = {1'b0, i_req.a} + {1'b0, w_b} + {{ALU_W{1'b0}}, w_sub};

    assign o_rsp.res   = w_full[ALU_W-1:0];
    assign o_rsp.carry = w_full[ALU_W];

endmodule

`default_nettype wire

// File: hw/rtl/urk_filter.sv
// Scalar Kalman update sequencer: restoring divide for the gain and two
// shift-add multiplies, all through one urk_alu. Depends on urk_pkg, urk_alu.
`default_nettype none
`include "ultrasonic_range_kalman_defines.svh"

module urk_filter import urk_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TICK_W-1:0] i_pw,
    input  t_cfg              i_cfg,
    output logic              o_busy,
    output logic              o_done,
    output logic [RAW_W-1:0]  o_raw,
    output logic [RAW_W-1:0]  o_filt
);

    typedef enum logic [3:0] {
        F_IDLE, F_DEN, F_DIV, F_DIFF, F_NEG, F_MUL1, F_EST, F_MUL2, F_COV, F_DONE
    } t_fstate;

    t_fstate                 r_state, n_state;
    logic [COV_W-1:0]        r_cov, n_cov;
    logic [EST_W-1:0]        r_est, n_est;
    logic [RAW_W-1:0]        r_raw, n_raw;
    logic [DEN_W-1:0]        r_den, n_den;
    logic                    r_den_zero, n_den_zero;
    logic [REM_W-1:0]        r_rem, n_rem;
    logic [FRAC_BITS-1:0]    r_k, n_k;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_neg, n_neg;
    logic [ALU_W-1:0]        r_acc, n_acc;
    logic [ALU_W-1:0]        r_mcand, n_mcand;
    logic [FRAC_BITS:0]      r_mplier, n_mplier;

    logic [TICK_W+RAW_MUL_W-1:0] w_raw_prod;
    logic [EST_W-1:0]            w_u;
    logic [FRAC_BITS:0]          w_kc;
    logic                        w_mul_last;
    t_alu_req                    w_req;
    t_alu_rsp                    w_rsp;

    urk_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign w_raw_prod = i_pw * RAW_MUL;
    assign w_u        = {r_raw, {FRAC_BITS{1'b0}}};
    assign w_kc       = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, r_k};
    assign w_mul_last = (r_state == F_MUL1) ? (r_cnt == CNT_W'(FRAC_BITS - 1))
                                            : (r_cnt == CNT_W'(FRAC_BITS));

    // operand select for the shared adder
    always_comb begin
        w_req.a  = '0;
        w_req.b  = '0;
        w_req.op = ALU_ADD;
        case (r_state)
            F_DEN: begin
                w_req.a = ALU_W'(r_cov);
                w_req.b = ALU_W'({i_cfg.mnoise, {FRAC_BITS{1'b0}}});
            end
            F_DIV: begin
                w_req.a  = ALU_W'({r_rem, 1'b0});
                w_req.b  = ALU_W'(r_den);
                w_req.op = ALU_SUB;
            end
            F_DIFF: begin
                w_req.a  = ALU_W'(w_u);
                w_req.b  = ALU_W'(r_est);
                w_req.op = ALU_SUB;
            end
            F_NEG: begin
                w_req.a  = ALU_W'(r_est);
                w_req.b  = ALU_W'(w_u);
                w_req.op = ALU_SUB;
            end
            F_MUL1, F_MUL2: begin
                w_req.a = r_acc;
                w_req.b = r_mplier[0] ? r_mcand : '0;
            end
            F_EST: begin
                w_req.a  = ALU_W'(r_est);
                w_req.b  = ALU_W'(r_acc[ALU_W-1:FRAC_BITS]);
                w_req.op = r_neg ? ALU_SUB : ALU_ADD;
            end
            F_COV: begin
                w_req.a = ALU_W'(r_acc[ALU_W-1:FRAC_BITS]);
                w_req.b = ALU_W'({i_cfg.pnoise, {FRAC_BITS{1'b0}}});
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cov      = r_cov;
        n_est      = r_est;
        n_raw      = r_raw;
        n_den      = r_den;
        n_den_zero = r_den_zero;
        n_rem      = r_rem;
        n_k        = r_k;
        n_cnt      = r_cnt;
        n_neg      = r_neg;
        n_acc      = r_acc;
        n_mcand    = r_mcand;
        n_mplier   = r_mplier;
        case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_raw   = w_raw_prod[RAW_SHIFT+RAW_W-1:RAW_SHIFT];
                    n_state = F_DEN;
                end
            end
            F_DEN: begin
                n_den      = w_rsp.res[DEN_W-1:0];
                n_den_zero = (w_rsp.res[DEN_W-1:0] == '0);
                n_rem      = REM_W'(r_cov);
                n_k        = '0;
                n_cnt      = '0;
                n_state    = F_DIV;
            end
            F_DIV: begin
                if (w_rsp.carry) begin
                    n_rem = w_rsp.res[REM_W-1:0];
                    n_k   = {r_k[FRAC_BITS-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[REM_W-2:0], 1'b0};
                    n_k   = {r_k[FRAC_BITS-2:0], 1'b0};
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(FRAC_BITS - 1)) begin
                    if (r_den_zero) begin
                        n_k = '0;   // no covariance and no noise: gain zero
                    end
                    n_state = F_DIFF;
                end
            end
            F_DIFF, F_NEG: begin
                if (r_state == F_DIFF && !w_rsp.carry) begin
                    n_neg   = 1'b1;
                    n_state = F_NEG;
                end else begin
                    if (r_state == F_DIFF) begin
                        n_neg = 1'b0;
                    end
                    n_mcand  = ALU_W'(w_rsp.res[EST_W-1:0]);
                    n_mplier = {1'b0, r_k};
                    n_acc    = '0;
                    n_cnt    = '0;
                    n_state  = F_MUL1;
                end
            end
            F_MUL1, F_MUL2: begin
                n_acc    = w_rsp.res;
                n_mcand  = {r_mcand[ALU_W-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[FRAC_BITS:1]};
                n_cnt    = r_cnt + CNT_W'(1);
                if (w_mul_last) begin
                    n_state = (r_state == F_MUL1) ? F_EST : F_COV;
                end
            end
            F_EST: begin
                n_est    = w_rsp.res[EST_W-1:0];
                n_mcand  = ALU_W'(r_cov);
                n_mplier = w_kc;
                n_acc    = '0;
                n_cnt    = '0;
                n_state  = F_MUL2;
            end
            F_COV: begin
                n_cov   = w_rsp.res[COV_W-1:0];
                n_state = F_DONE;
            end
            F_DONE: n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cov   <= '0;
            r_est   <= '0;
        end else begin
            r_state    <= n_state;
            r_cov      <= n_cov;
            r_est      <= n_est;
            r_raw      <= n_raw;
            r_den      <= n_den;
            r_den_zero <= n_den_zero;
            r_rem      <= n_rem;
            r_k        <= n_k;
            r_cnt      <= n_cnt;
            r_neg      <= n_neg;
            r_acc      <= n_acc;
            r_mcand    <= n_mcand;
            r_mplier   <= n_mplier;
        end
    end

    assign o_busy = (r_state != F_IDLE);
    assign o_done = (r_state == F_DONE);
    assign o_raw  = r_raw;
    assign o_filt = r_est[EST_W-1:FRAC_BITS];

    // partial remainder never exceeds the divisor
    `URK_ASSERT_IMM(a_rem_bounded, r_state == F_DIV, r_rem <= REM_W'(r_den), "remainder above divisor")
    // the estimate moves toward the measurement and never past it
    `URK_ASSERT_NXT(a_est_no_over_up, r_state == F_EST && !r_neg, r_est <= w_u, "estimate overshoot up")
    `URK_ASSERT_NXT(a_est_no_over_dn, r_state == F_EST && r_neg, r_est >= w_u, "estimate overshoot down")

endmodule

`default_nettype wire

// File: hw/rtl/ultrasonic_range_kalman.sv
// Flow: a word that does not end a measurement passes through the publish state into the
//   output register; the next word is taken once that result is in the output register.
// A word that ends a measurement runs the Kalman update on the shared 58-bit adder (16 divide
//   steps, 16 + 17 shift-add steps) before its result is offered.
// Reset (synchronous, active low): phase idle, estimate and covariance zero, registers to
//   timeout 50000, R 40, Q 10. No clearing pass.
`default_nettype none
`include "ultrasonic_range_kalman_defines.svh"

module ultrasonic_range_kalman import urk_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    urk_in_if.sink             i_req,
    urk_out_if.source          o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_RISE, PH_HIGH} t_phase;
    typedef enum logic [1:0] {ST_IN, ST_FILT, ST_PUB} t_state;

    typedef struct packed {
        logic             trigger;
        logic             busy_res;
        logic             done_res;
        logic [RAW_W-1:0] raw_distance;
        logic [RAW_W-1:0] kalman_distance;
    } t_res;

    t_cfg                    w_cfg;
    t_phase                  r_phase, n_phase;
    logic [SENSOR_W-1:0]     r_sel, n_sel;
    logic [TICK_W-1:0]       r_pt, n_pt;
    logic [TICK_W-1:0]       r_pw, n_pw;
    t_state                  r_state;
    logic                    r_go;
    t_res                    r_res;
    t_res                    r_odata;
    logic                    r_ovalid;

    logic                    w_fire;
    logic                    w_fin;
    logic                    w_inv;
    logic                    w_echo;
    logic                    w_lt;
    logic [TICK_W-1:0]       w_pt_inc;
    logic [(1<<SENSOR_W)-1:0] w_lv_ext;
    logic                    w_fbusy;
    logic                    w_fdone;
    logic [RAW_W-1:0]        w_fraw;
    logic [RAW_W-1:0]        w_ffilt;
    logic                    w_pub;

    urk_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    urk_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_pw    (r_pw),
        .i_cfg   (w_cfg),
        .o_busy  (w_fbusy),
        .o_done  (w_fdone),
        .o_raw   (w_fraw),
        .o_filt  (w_ffilt)
    );

    assign i_req.ready = (r_state == ST_IN);
    assign w_fire      = i_req.valid && i_req.ready;
    assign w_lv_ext    = (1 << SENSOR_W)'(i_req.echo_levels);
    assign w_echo      = w_lv_ext[r_sel];
    assign w_pt_inc    = r_pt + TICK_W'(1);
    assign w_lt        = (r_pt < w_cfg.timeout);

    // echo timing for one word
    always_comb begin
        n_phase = r_phase;
        n_sel   = r_sel;
        n_pt    = r_pt;
        n_pw    = r_pw;
        w_fin   = 1'b0;
        w_inv   = 1'b0;
        if (i_req.command == CMD_START) begin
            if (r_phase == PH_IDLE) begin
                if (i_req.sensor >= SENSOR_W'(SENSOR_COUNT)) begin
                    w_inv = 1'b1;
                end else begin
                    n_sel   = i_req.sensor;
                    n_phase = PH_TRIG;
                    n_pt    = '0;
                    n_pw    = '0;
                end
            end
        end else begin
            case (r_phase)
                PH_TRIG: begin
                    if (w_pt_inc >= TICK_W'(TRIGGER_TICKS)) begin
                        n_phase = PH_RISE;
                        n_pt    = '0;
                    end else begin
                        n_pt = w_pt_inc;
                    end
                end
                PH_RISE: begin
                    if (!w_echo && w_lt) begin
                        n_pt = w_pt_inc;
                        if (w_pt_inc >= w_cfg.timeout) begin
                            n_phase = PH_HIGH;
                            n_pt    = '0;
                            n_pw    = '0;
                        end
                    end else begin
                        n_phase = PH_HIGH;
                        n_pt    = '0;
                        n_pw    = '0;
                        // rising tick already counts as the first high tick
                        if (w_echo && w_cfg.timeout != '0) begin
                            n_pt = TICK_W'(1);
                            n_pw = TICK_W'(1);
                            if (w_cfg.timeout <= TICK_W'(1)) begin
                                w_fin = 1'b1;
                            end
                        end else begin
                            w_fin = 1'b1;
                        end
                    end
                end
                PH_HIGH: begin
                    if (w_echo && w_lt) begin
                        n_pt = w_pt_inc;
                        n_pw = w_pt_inc;
                        if (w_pt_inc >= w_cfg.timeout) begin
                            w_fin = 1'b1;
                        end
                    end else begin
                        w_fin = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (w_fin) begin
            n_phase = PH_IDLE;
            n_pt    = '0;
        end
    end

    assign w_pub = (r_state == ST_PUB) && (!r_ovalid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_sel    <= '0;
            r_pt     <= '0;
            r_pw     <= '0;
            r_state  <= ST_IN;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_go <= w_fire && w_fin;
            if (w_pub) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IN: begin
                    if (w_fire) begin
                        r_phase               <= n_phase;
                        r_sel                 <= n_sel;
                        r_pt                  <= n_pt;
                        r_pw                  <= n_pw;
                        r_res.trigger         <= (n_phase == PH_TRIG);
                        r_res.busy_res        <= (n_phase != PH_IDLE);
                        r_res.done_res        <= w_fin || w_inv;
                        r_res.raw_distance    <= '0;
                        r_res.kalman_distance <= '0;
                        r_state               <= w_fin ? ST_FILT : ST_PUB;
                    end
                end
                ST_FILT: begin
                    if (w_fdone) begin
                        r_res.raw_distance    <= w_fraw;
                        r_res.kalman_distance <= w_ffilt;
                        r_state               <= ST_PUB;
                    end
                end
                ST_PUB: begin
                    if (w_pub) begin
                        r_odata <= r_res;
                        r_state <= ST_IN;
                    end
                end
                default: r_state <= ST_IN;
            endcase
        end
    end

    assign o_res.valid           = r_ovalid;
    assign o_res.trigger         = r_odata.trigger;
    assign o_res.busy_res        = r_odata.busy_res;
    assign o_res.done_res        = r_odata.done_res;
    assign o_res.raw_distance    = r_odata.raw_distance;
    assign o_res.kalman_distance = r_odata.kalman_distance;

    `URK_ASSERT_NXT(a_one_word_at_a_time, w_fire, !i_req.ready, "input taken while a word is in work")
    `URK_ASSERT_IMM(a_fdone_in_filt, w_fdone, r_state == ST_FILT, "filter done outside filter wait")
    `URK_ASSERT_IMM(a_start_when_idle, r_go, !w_fbusy, "filter started while busy")
    `URK_ASSERT_IMM(a_done_not_busy, r_ovalid && r_odata.done_res, !r_odata.busy_res, "done word still busy")

endmodule

`default_nettype wire
